### hw/rtl/dld_pkg.sv
`timescale 1ns / 1ps
package dld_pkg;

  // field widths fixed by the interface
  localparam int CAM_W      = 20;
  localparam int RAD_W      = 42;
  localparam int KP_W       = 48;
  localparam int PER_W      = 12;
  localparam int SEED_W     = 32;
  localparam int TAG_W      = 32;
  localparam int CNT_W      = 32;
  localparam int LAYER_W    = 2;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 48;
  localparam int NUM_RAD    = 3;

  localparam int NUM_LAYERS_DEF = 3;
  localparam int COORD_BITS_DEF = 20;

  localparam logic [SEED_W-1:0] LFSR_TAPS = 32'h8020_0003;

  // remainder unit: four dividend bits per cycle
  localparam int MOD_DIGIT = 4;
  localparam int MOD_ITERS = SEED_W / MOD_DIGIT;
  localparam int MOD_CNT_W = $clog2(MOD_ITERS);

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_POINT = 1'b1;

  localparam logic [1:0] BG_FIELD = 2'd3;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_CAM_X   = 3'd0,
    CFG_CAM_Y   = 3'd1,
    CFG_CAM_Z   = 3'd2,
    CFG_RAD_0   = 3'd3,
    CFG_RAD_1   = 3'd4,
    CFG_RAD_2   = 3'd5,
    CFG_PERIODS = 3'd6,
    CFG_SEED    = 3'd7
  } cfg_addr_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ABS,
    ST_MUL,
    ST_SUM,
    ST_CLS,
    ST_UPD,
    ST_DRAW,
    ST_DIV,
    ST_WR
  } state_t;

  typedef struct packed {
    logic load_in;
    logic slot_clr;
    logic cls_en;
    logic upd_en;
    logic draw_en;
    logic start_wr;
    logic phase_wr;
    logic slot_inc;
  } cmd_t;

  typedef struct packed {
    logic wrap;
    logic div_done;
    logic slot_last;
    logic out_free;
  } stat_t;

  // a zero period acts as one
  function automatic logic [PER_W-1:0] period_of(input logic [KP_W-1:0] kp,
                                                 input logic [1:0] fld);
    logic [PER_W-1:0] p;
    unique case (fld)
      2'd0:    p = kp[PER_W-1:0];
      2'd1:    p = kp[2*PER_W-1:PER_W];
      2'd2:    p = kp[3*PER_W-1:2*PER_W];
      default: p = kp[4*PER_W-1:3*PER_W];
    endcase
    return (p == '0) ? PER_W'(1) : p;
  endfunction

  function automatic logic [SEED_W-1:0] lfsr_step(input logic [SEED_W-1:0] v);
    logic [SEED_W-1:0] n;
    n = v >> 1;
    if (v[0]) begin
      n = n ^ LFSR_TAPS;
    end
    return n;
  endfunction

endpackage

### hw/rtl/distance_layered_point_decimator.sv
`timescale 1ns / 1ps
// Thins a point stream around a camera. A point word takes its squared
// distance to the camera through a difference, a multiplier and an adder
// stage, lands in the first radius layer that holds it (or the background
// layer) and is kept once per layer period at a pseudo-random phase; one
// result word comes back per point, none for a start word. A point passes
// through the difference, square, sum, classify and update states before
// the next word is taken; when its layer period runs out a new phase is
// drawn through the 4-bit-per-cycle remainder unit. A start word draws a
// phase for every layer, the background layer included. The output word
// register lets the next word be taken while a result waits.
module distance_layered_point_decimator #(
  parameter int NUM_LAYERS = dld_pkg::NUM_LAYERS_DEF,
  parameter int COORD_BITS = dld_pkg::COORD_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_cmd,
  input  logic signed [COORD_BITS-1:0]       in_coord_x,
  input  logic signed [COORD_BITS-1:0]       in_coord_y,
  input  logic signed [COORD_BITS-1:0]       in_coord_z,
  input  logic [dld_pkg::TAG_W-1:0]          in_row_tag,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_keep,
  output logic [dld_pkg::LAYER_W-1:0]        out_layer,
  output logic [dld_pkg::TAG_W-1:0]          out_tag_out,
  output logic [dld_pkg::CNT_W-1:0]          out_layer_kept_count,
  input  logic                               cfg_we,
  input  logic [dld_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [dld_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import dld_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  dld_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_cmd   (in_cmd),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  dld_dpath #(
    .NUM_LAYERS (NUM_LAYERS),
    .COORD_BITS (COORD_BITS)
  ) u_dpath (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .stat                 (stat),
    .in_coord_x           (in_coord_x),
    .in_coord_y           (in_coord_y),
    .in_coord_z           (in_coord_z),
    .in_row_tag           (in_row_tag),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_keep             (out_keep),
    .out_layer            (out_layer),
    .out_tag_out          (out_tag_out),
    .out_layer_kept_count (out_layer_kept_count),
    .cfg_we               (cfg_we),
    .cfg_addr             (cfg_addr),
    .cfg_wdata            (cfg_wdata)
  );

endmodule

### hw/rtl/dld_mod.sv
`timescale 1ns / 1ps
module dld_mod (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [dld_pkg::SEED_W-1:0]  dividend,
  input  logic [dld_pkg::PER_W-1:0]   divisor,
  output logic [dld_pkg::PER_W-1:0]   rem,
  output logic                        done
);
  import dld_pkg::*;

  logic                 busy_r;
  logic                 done_r;
  logic [MOD_CNT_W-1:0] cnt_r;
  logic [SEED_W-1:0]    dvd_r;
  logic [PER_W-1:0]     dsr_r;
  logic [PER_W-1:0]     rem_r;
  logic [PER_W-1:0]     rem_nxt;

  // restoring remainder, one digit per cycle; partial stays below divisor
  always_comb begin
    logic [PER_W:0] t;
    rem_nxt = rem_r;
    for (int k = 0; k < MOD_DIGIT; k++) begin
      t = {rem_nxt, dvd_r[SEED_W-1-k]};
      if (t >= {1'b0, dsr_r}) begin
        t = t - {1'b0, dsr_r};
      end
      rem_nxt = t[PER_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == MOD_CNT_W'(MOD_ITERS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dsr_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= dvd_r << MOD_DIGIT;
      rem_r <= rem_nxt;
    end
  end

  assign rem  = rem_r;
  assign done = done_r;

endmodule

### hw/rtl/dld_dpath.sv
`timescale 1ns / 1ps
module dld_dpath #(
  parameter int NUM_LAYERS = dld_pkg::NUM_LAYERS_DEF,
  parameter int COORD_BITS = dld_pkg::COORD_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  dld_pkg::cmd_t                      cmd,
  output dld_pkg::stat_t                     stat,
  input  logic signed [COORD_BITS-1:0]       in_coord_x,
  input  logic signed [COORD_BITS-1:0]       in_coord_y,
  input  logic signed [COORD_BITS-1:0]       in_coord_z,
  input  logic [dld_pkg::TAG_W-1:0]          in_row_tag,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_keep,
  output logic [dld_pkg::LAYER_W-1:0]        out_layer,
  output logic [dld_pkg::TAG_W-1:0]          out_tag_out,
  output logic [dld_pkg::CNT_W-1:0]          out_layer_kept_count,
  input  logic                               cfg_we,
  input  logic [dld_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [dld_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import dld_pkg::*;

  localparam int SLOTS  = NUM_LAYERS + 1;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int DIFF_W = ((COORD_BITS > CAM_W) ? COORD_BITS : CAM_W) + 1;
  localparam int SQ_W   = 2 * DIFF_W;
  localparam int SUM_W  = (SQ_W + 2 > 64) ? 64 : SQ_W + 2;
  localparam int RAD_N  = (NUM_LAYERS > NUM_RAD) ? NUM_LAYERS : NUM_RAD;

  // configuration
  logic signed [CAM_W-1:0] cam_x_r, cam_y_r, cam_z_r;
  logic [RAD_W-1:0]        rad_r [NUM_RAD];
  logic [KP_W-1:0]         kp_r;
  logic [SEED_W-1:0]       lfsr_r;
  logic [SEED_W-1:0]       lfsr_nxt;

  // per-layer state
  logic [PER_W-1:0] cd_r   [SLOTS];
  logic [PER_W-1:0] ph_r   [SLOTS];
  logic [CNT_W-1:0] kept_r [SLOTS];

  // point pipeline
  logic signed [COORD_BITS-1:0] px_r, py_r, pz_r;
  logic [TAG_W-1:0]             tag_r;
  logic [DIFF_W-1:0]            ax_r, ay_r, az_r;
  logic [SQ_W-1:0]              sx_r, sy_r, sz_r;
  logic [SUM_W-1:0]             d2_r;
  logic [SLOT_W-1:0]            idx_r;

  logic signed [DIFF_W-1:0] dx, dy, dz;
  logic [RAD_W-1:0]         rad_ext [RAD_N];
  logic [SLOT_W-1:0]        lay;
  logic [1:0]               fld;
  logic [PER_W-1:0]         per;
  logic [PER_W-1:0]         cd_dec;
  logic                     keep;
  logic [CNT_W-1:0]         kept_new;
  logic [PER_W-1:0]         rem;
  logic                     div_done;

  logic                     out_valid_r;
  logic                     out_keep_r;
  logic [LAYER_W-1:0]       out_layer_r;
  logic [TAG_W-1:0]         out_tag_r;
  logic [CNT_W-1:0]         out_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cam_x_r <= '0;
      cam_y_r <= '0;
      cam_z_r <= '0;
      for (int i = 0; i < NUM_RAD; i++) begin
        rad_r[i] <= '0;
      end
      kp_r <= KP_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_addr_t'(cfg_addr))
        CFG_CAM_X:   cam_x_r  <= cfg_wdata[CAM_W-1:0];
        CFG_CAM_Y:   cam_y_r  <= cfg_wdata[CAM_W-1:0];
        CFG_CAM_Z:   cam_z_r  <= cfg_wdata[CAM_W-1:0];
        CFG_RAD_0:   rad_r[0] <= cfg_wdata[RAD_W-1:0];
        CFG_RAD_1:   rad_r[1] <= cfg_wdata[RAD_W-1:0];
        CFG_RAD_2:   rad_r[2] <= cfg_wdata[RAD_W-1:0];
        CFG_PERIODS: kp_r     <= cfg_wdata[KP_W-1:0];
        default:     ;
      endcase
    end
  end

  assign lfsr_nxt = lfsr_step(lfsr_r);

  // a seed write reloads the generator; zero would lock it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lfsr_r <= SEED_W'(1);
    end else if (cfg_we && cfg_addr_t'(cfg_addr) == CFG_SEED) begin
      lfsr_r <= (cfg_wdata[SEED_W-1:0] == '0) ? SEED_W'(1) : cfg_wdata[SEED_W-1:0];
    end else if (cmd.draw_en) begin
      lfsr_r <= lfsr_nxt;
    end
  end

  // distance: difference, square, sum
  assign dx = DIFF_W'(px_r) - DIFF_W'(cam_x_r);
  assign dy = DIFF_W'(py_r) - DIFF_W'(cam_y_r);
  assign dz = DIFF_W'(pz_r) - DIFF_W'(cam_z_r);

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      px_r  <= in_coord_x;
      py_r  <= in_coord_y;
      pz_r  <= in_coord_z;
      tag_r <= in_row_tag;
    end
    ax_r <= dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
    ay_r <= dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
    az_r <= dz[DIFF_W-1] ? DIFF_W'(-dz) : DIFF_W'(dz);
    sx_r <= SQ_W'(ax_r) * SQ_W'(ax_r);
    sy_r <= SQ_W'(ay_r) * SQ_W'(ay_r);
    sz_r <= SQ_W'(az_r) * SQ_W'(az_r);
    d2_r <= SUM_W'(sx_r) + SUM_W'(sy_r) + SUM_W'(sz_r);
  end

  // layers past the third have no radius register and match only zero distance
  always_comb begin
    for (int i = 0; i < RAD_N; i++) begin
      rad_ext[i] = '0;
    end
    for (int i = 0; i < NUM_RAD; i++) begin
      rad_ext[i] = rad_r[i];
    end
  end

  always_comb begin
    lay = SLOT_W'(NUM_LAYERS);
    for (int i = NUM_LAYERS - 1; i >= 0; i--) begin
      if (d2_r <= SUM_W'(rad_ext[i])) begin
        lay = SLOT_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (cmd.slot_clr) begin
      idx_r <= '0;
    end else if (cmd.cls_en) begin
      idx_r <= lay;
    end else if (cmd.slot_inc) begin
      idx_r <= idx_r + 1'b1;
    end
  end

  assign fld      = (4'(idx_r) >= 4'(BG_FIELD)) ? BG_FIELD : 2'(idx_r);
  assign per      = period_of(kp_r, fld);
  assign cd_dec   = cd_r[idx_r] - 1'b1;
  assign keep     = (cd_dec == ph_r[idx_r]);
  assign kept_new = (keep && kept_r[idx_r] != '1) ? kept_r[idx_r] + 1'b1 : kept_r[idx_r];

  dld_mod u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.draw_en),
    .dividend (lfsr_nxt),
    .divisor  (per),
    .rem      (rem),
    .done     (div_done)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        cd_r[i]   <= PER_W'(1);
        ph_r[i]   <= '0;
        kept_r[i] <= '0;
      end
    end else if (cmd.upd_en) begin
      kept_r[idx_r] <= kept_new;
      cd_r[idx_r]   <= (cd_dec == '0) ? per : cd_dec;
    end else if (cmd.start_wr) begin
      cd_r[idx_r]   <= per;
      ph_r[idx_r]   <= (rem == '0) ? '0 : rem - 1'b1;
      kept_r[idx_r] <= '0;
    end else if (cmd.phase_wr) begin
      ph_r[idx_r] <= rem;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.upd_en) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.upd_en) begin
      out_keep_r  <= keep;
      out_layer_r <= LAYER_W'(idx_r);
      out_tag_r   <= tag_r;
      out_cnt_r   <= kept_new;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_keep             = out_keep_r;
  assign out_layer            = out_layer_r;
  assign out_tag_out          = out_tag_r;
  assign out_layer_kept_count = out_cnt_r;

  assign stat.wrap      = (cd_dec == '0);
  assign stat.div_done  = div_done;
  assign stat.slot_last = (idx_r == SLOT_W'(NUM_LAYERS));
  assign stat.out_free  = !out_valid_r || !out_stall;

endmodule

### hw/rtl/dld_ctrl.sv
`timescale 1ns / 1ps
module dld_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_cmd,
  output logic           in_stall,
  input  dld_pkg::stat_t stat,
  output dld_pkg::cmd_t  cmd
);
  import dld_pkg::*;

  state_t state_r, state_nxt;
  logic   mode_start_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      mode_start_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_IDLE && in_valid) begin
        mode_start_r <= (in_cmd == CMD_START);
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_cmd == CMD_START) ? ST_DRAW : ST_ABS;
        end
      end
      ST_ABS:  state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_SUM;
      ST_SUM:  state_nxt = ST_CLS;
      ST_CLS:  state_nxt = ST_UPD;
      ST_UPD: begin
        if (stat.out_free) begin
          state_nxt = stat.wrap ? ST_DIV : ST_IDLE;
        end
      end
      ST_DRAW: state_nxt = ST_DIV;
      ST_DIV: begin
        if (stat.div_done) begin
          state_nxt = ST_WR;
        end
      end
      ST_WR: begin
        state_nxt = (mode_start_r && !stat.slot_last) ? ST_DRAW : ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall     = 1'b0;
        cmd.load_in  = in_valid;
        cmd.slot_clr = in_valid && (in_cmd == CMD_START);
      end
      ST_CLS: cmd.cls_en = 1'b1;
      ST_UPD: begin
        cmd.upd_en  = stat.out_free;
        cmd.draw_en = stat.out_free && stat.wrap;
      end
      ST_DRAW: cmd.draw_en = 1'b1;
      ST_WR: begin
        cmd.start_wr = mode_start_r;
        cmd.phase_wr = !mode_start_r;
        cmd.slot_inc = mode_start_r && !stat.slot_last;
      end
      default: ;
    endcase
  end

endmodule

### sim/dld_result_checker.sv
`timescale 1ns / 1ps
module dld_result_checker
  import dld_pkg::*;
(
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic                              in_cmd,
  input  logic signed [COORD_BITS_DEF-1:0]  in_coord_x,
  input  logic signed [COORD_BITS_DEF-1:0]  in_coord_y,
  input  logic signed [COORD_BITS_DEF-1:0]  in_coord_z,
  input  logic [TAG_W-1:0]                  in_row_tag,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic                              out_keep,
  input  logic [LAYER_W-1:0]                out_layer,
  input  logic [TAG_W-1:0]                  out_tag_out,
  input  logic [CNT_W-1:0]                  out_layer_kept_count,
  input  logic                              cfg_we,
  input  logic [CFG_ADDR_W-1:0]             cfg_addr,
  input  logic [CFG_DATA_W-1:0]             cfg_wdata,
  output int                                error_count,
  output int                                results_due
);

  localparam int SLOTS = NUM_LAYERS_DEF + 1;

  typedef struct packed {
    logic               keep;
    logic [LAYER_W-1:0] layer;
    logic [TAG_W-1:0]   tag;
    logic [CNT_W-1:0]   kept;
  } point_result_t;

  logic signed [CAM_W-1:0] cam_x, cam_y, cam_z;
  logic [RAD_W-1:0]        radius_sq [NUM_RAD];
  logic [KP_W-1:0]         periods;
  logic [PER_W-1:0]        ticks_left [SLOTS];
  logic [PER_W-1:0]        pick_at [SLOTS];
  logic [SEED_W-1:0]       prng;
  logic [CNT_W-1:0]        kept_so_far [SLOTS];
  point_result_t           due_q [$];

  function automatic logic [PER_W-1:0] layer_period(input int slot);
    logic [PER_W-1:0] p;
    p = periods[slot*PER_W +: PER_W];
    return (p == '0) ? PER_W'(1) : p;
  endfunction

  // galois step, then the new value modulo the period
  function automatic logic [PER_W-1:0] draw_mod(input logic [PER_W-1:0] p);
    logic lsb;
    lsb = prng[0];
    prng = prng >> 1;
    if (lsb) begin
      prng = prng ^ LFSR_TAPS;
    end
    return PER_W'(prng % SEED_W'(p));
  endfunction

  function automatic logic [63:0] square_off(input logic signed [CAM_W-1:0] v,
                                             input logic signed [CAM_W-1:0] c);
    longint d;
    d = longint'(v) - longint'(c);
    if (d < 0) begin
      d = -d;
    end
    return 64'(d * d);
  endfunction

  task automatic restart_layers;
    logic [PER_W-1:0] p;
    logic [PER_W-1:0] r;
    for (int slot = 0; slot < SLOTS; slot++) begin
      p = layer_period(slot);
      r = draw_mod(p);
      ticks_left[slot] = p;
      pick_at[slot] = (r == '0) ? '0 : r - PER_W'(1);
      kept_so_far[slot] = '0;
    end
  endtask

  task automatic decimate_point(output point_result_t res);
    logic [63:0]      d2;
    logic [LAYER_W-1:0] layer;
    logic             keep;
    int               slot;
    logic [PER_W-1:0] p;
    d2 = square_off(in_coord_x, cam_x) + square_off(in_coord_y, cam_y)
       + square_off(in_coord_z, cam_z);
    // walk down so the lowest matching layer wins
    layer = BG_FIELD;
    for (int i = NUM_RAD - 1; i >= 0; i--) begin
      if (d2 <= {22'd0, radius_sq[i]}) begin
        layer = LAYER_W'(i);
      end
    end
    slot = int'(layer);
    keep = (ticks_left[slot] - PER_W'(1)) == pick_at[slot];
    if (keep && kept_so_far[slot] != '1) begin
      kept_so_far[slot] = kept_so_far[slot] + 1'b1;
    end
    ticks_left[slot] = ticks_left[slot] - PER_W'(1);
    if (ticks_left[slot] == '0) begin
      p = layer_period(slot);
      pick_at[slot] = draw_mod(p);
      ticks_left[slot] = p;
    end
    res.keep  = keep;
    res.layer = layer;
    res.tag   = in_row_tag;
    res.kept  = kept_so_far[slot];
  endtask

  task automatic report(input string what, input logic [63:0] want,
                        input logic [63:0] got);
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    error_count++;
  endtask

  always @(posedge clk) begin
    point_result_t want;
    point_result_t got;
    if (!rst_n) begin
      cam_x = '0;
      cam_y = '0;
      cam_z = '0;
      for (int i = 0; i < NUM_RAD; i++) begin
        radius_sq[i] = '0;
      end
      periods = KP_W'(1);
      prng = SEED_W'(1);
      for (int slot = 0; slot < SLOTS; slot++) begin
        ticks_left[slot] = layer_period(slot);
        pick_at[slot] = '0;
        kept_so_far[slot] = '0;
      end
      due_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_addr_t'(cfg_addr))
          CFG_CAM_X:   cam_x = cfg_wdata[CAM_W-1:0];
          CFG_CAM_Y:   cam_y = cfg_wdata[CAM_W-1:0];
          CFG_CAM_Z:   cam_z = cfg_wdata[CAM_W-1:0];
          CFG_RAD_0:   radius_sq[0] = cfg_wdata[RAD_W-1:0];
          CFG_RAD_1:   radius_sq[1] = cfg_wdata[RAD_W-1:0];
          CFG_RAD_2:   radius_sq[2] = cfg_wdata[RAD_W-1:0];
          CFG_PERIODS: periods = cfg_wdata[KP_W-1:0];
          CFG_SEED: begin
            // a zero seed would lock the generator
            prng = (cfg_wdata[SEED_W-1:0] == '0) ? SEED_W'(1) : cfg_wdata[SEED_W-1:0];
          end
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        got.keep  = out_keep;
        got.layer = out_layer;
        got.tag   = out_tag_out;
        got.kept  = out_layer_kept_count;
        if (due_q.size() == 0) begin
          $display("%0t: result word with none expected, got tag %0d", $time, got.tag);
          error_count++;
        end else begin
          want = due_q.pop_front();
          if (got.keep !== want.keep) report("keep", 64'(want.keep), 64'(got.keep));
          if (got.layer !== want.layer) report("layer", 64'(want.layer), 64'(got.layer));
          if (got.tag !== want.tag) report("tag_out", 64'(want.tag), 64'(got.tag));
          if (got.kept !== want.kept) begin
            report("layer_kept_count", 64'(want.kept), 64'(got.kept));
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (in_cmd == CMD_START) begin
          restart_layers();
        end else begin
          decimate_point(want);
          due_q = {due_q, want};
        end
      end
    end
    results_due <= due_q.size();
  end

endmodule

### sim/distance_layered_point_decimator_tb.sv
`timescale 1ns / 1ps
module distance_layered_point_decimator_tb;
  import dld_pkg::*;

  localparam int RANDOM_PHASES   = 8;
  localparam int WORDS_PER_PHASE = 220;
  localparam int SETTLE_CYCLES   = 80;
  localparam int HOLD_CYCLES     = 400;

  localparam logic signed [CAM_W-1:0] CMIN = -20'sd524288;
  localparam logic signed [CAM_W-1:0] CMAX = 20'sd524287;
  localparam logic [RAD_W-1:0] RAD_MAX = 42'd3298534883328;

  typedef enum int {FLOW, SPARSE, HEAVY, BEAT} stall_mode_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic                    in_cmd = CMD_POINT;
  logic signed [CAM_W-1:0] in_coord_x = '0;
  logic signed [CAM_W-1:0] in_coord_y = '0;
  logic signed [CAM_W-1:0] in_coord_z = '0;
  logic [TAG_W-1:0]        in_row_tag = '0;

  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic                    out_keep;
  logic [LAYER_W-1:0]      out_layer;
  logic [TAG_W-1:0]        out_tag_out;
  logic [CNT_W-1:0]        out_layer_kept_count;

  logic                    cfg_we = 1'b0;
  cfg_addr_t               cfg_addr = CFG_CAM_X;
  logic [CFG_DATA_W-1:0]   cfg_wdata = '0;

  int error_count;
  int results_due;

  logic        hold_req = 1'b0;
  logic        hold_ack = 1'b0;
  int          hold_left = 0;
  int          pat_left = 0;
  stall_mode_t stall_mode = FLOW;
  int          burst_left = 0;

  // camera as last programmed, used to aim points
  logic signed [CAM_W-1:0] cam_x = '0;
  logic signed [CAM_W-1:0] cam_y = '0;
  logic signed [CAM_W-1:0] cam_z = '0;
  int reach = 19;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  distance_layered_point_decimator uut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_cmd               (in_cmd),
    .in_coord_x           (in_coord_x),
    .in_coord_y           (in_coord_y),
    .in_coord_z           (in_coord_z),
    .in_row_tag           (in_row_tag),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_keep             (out_keep),
    .out_layer            (out_layer),
    .out_tag_out          (out_tag_out),
    .out_layer_kept_count (out_layer_kept_count),
    .cfg_we               (cfg_we),
    .cfg_addr             (cfg_addr),
    .cfg_wdata            (cfg_wdata)
  );

  dld_result_checker chk (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_cmd               (in_cmd),
    .in_coord_x           (in_coord_x),
    .in_coord_y           (in_coord_y),
    .in_coord_z           (in_coord_z),
    .in_row_tag           (in_row_tag),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_keep             (out_keep),
    .out_layer            (out_layer),
    .out_tag_out          (out_tag_out),
    .out_layer_kept_count (out_layer_kept_count),
    .cfg_we               (cfg_we),
    .cfg_addr             (cfg_addr),
    .cfg_wdata            (cfg_wdata),
    .error_count          (error_count),
    .results_due          (results_due)
  );

  // receiver: shifting stall patterns, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      if (pat_left == 0) begin
        stall_mode <= stall_mode_t'($urandom_range(0, 3));
        pat_left <= $urandom_range(16, 160);
      end else begin
        pat_left <= pat_left - 1;
      end
      case (stall_mode)
        FLOW:    out_stall <= 1'b0;
        SPARSE:  out_stall <= ($urandom_range(0, 3) == 0);
        HEAVY:   out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= pat_left[2];
      endcase
    end
  end

  task automatic write_reg(input cfg_addr_t a, input logic [CFG_DATA_W-1:0] d);
    cfg_we <= 1'b1;
    cfg_addr <= a;
    cfg_wdata <= d;
    @(posedge clk);
  endtask

  // unused upper bits of the write data carry junk
  task automatic program_regs(input logic signed [CAM_W-1:0] cx,
                              input logic signed [CAM_W-1:0] cy,
                              input logic signed [CAM_W-1:0] cz,
                              input logic [RAD_W-1:0] r0,
                              input logic [RAD_W-1:0] r1,
                              input logic [RAD_W-1:0] r2,
                              input logic [KP_W-1:0] kp,
                              input logic [SEED_W-1:0] seed);
    logic [63:0] junk;
    junk = {$urandom(), $urandom()};
    write_reg(CFG_CAM_X, {junk[47:20], cx});
    write_reg(CFG_CAM_Y, {junk[43:16], cy});
    write_reg(CFG_CAM_Z, {junk[39:12], cz});
    write_reg(CFG_RAD_0, {junk[47:42], r0});
    write_reg(CFG_RAD_1, {junk[5:0], r1});
    write_reg(CFG_RAD_2, {junk[11:6], r2});
    write_reg(CFG_PERIODS, kp);
    write_reg(CFG_SEED, {junk[63:48], seed});
    cfg_we <= 1'b0;
    cam_x = cx;
    cam_y = cy;
    cam_z = cz;
  endtask

  task automatic send_word(input logic cmd, input logic signed [CAM_W-1:0] x,
                           input logic signed [CAM_W-1:0] y,
                           input logic signed [CAM_W-1:0] z,
                           input logic [TAG_W-1:0] tag);
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_coord_x <= x;
    in_coord_y <= y;
    in_coord_z <= z;
    in_row_tag <= tag;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 90)
                                               : $urandom_range(0, 8);
    end
  endtask

  task automatic send_start;
    send_word(CMD_START, CAM_W'($urandom()), CAM_W'($urandom()), CAM_W'($urandom()),
              $urandom());
  endtask

  task automatic send_point(input logic signed [CAM_W-1:0] x,
                            input logic signed [CAM_W-1:0] y,
                            input logic signed [CAM_W-1:0] z);
    send_word(CMD_POINT, x, y, z, $urandom());
  endtask

  function automatic logic signed [CAM_W-1:0] aim(input logic signed [CAM_W-1:0] c,
                                                  input int k);
    int off;
    off = $urandom_range(0, 1 << k);
    if ($urandom_range(0, 1) == 1) begin
      off = -off;
    end
    return c + CAM_W'(off);
  endfunction

  // wait out every result, then the tail of any start or draw still running
  task automatic drain;
    in_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (results_due != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_random(input int phase);
    logic [RAD_W-1:0] r [3];
    logic [KP_W-1:0]  kp;
    logic [RAD_W-1:0] t;
    int               ex [3];
    ex[0] = $urandom_range(2, 7);
    ex[1] = ex[0] + $urandom_range(1, 4);
    ex[2] = ex[1] + $urandom_range(1, 4);
    for (int i = 0; i < 3; i++) begin
      r[i] = RAD_W'({$urandom(), $urandom()} >> (64 - 2 * ex[i]));
    end
    reach = ex[2] + 1;
    for (int f = 0; f < 4; f++) begin
      kp[f*PER_W +: PER_W] = ($urandom_range(0, 9) == 0) ? PER_W'($urandom())
                                                          : PER_W'($urandom_range(0, 6));
    end
    case (phase)
      0: begin
        r[2] = RAD_MAX;
        kp = '1;
      end
      1: begin
        r[0] = '0;
        r[1] = '0;
        r[2] = '0;
        kp = '0;
      end
      2: begin
        // radii out of order
        t = r[0];
        r[0] = r[2];
        r[2] = t;
        kp = KP_W'({$urandom(), $urandom()});
      end
      default: ;
    endcase
    program_regs(CAM_W'($urandom()), CAM_W'($urandom()), CAM_W'($urandom()),
                 r[0], r[1], r[2], kp, $urandom());
  endtask

  initial begin
    int pick;
    int k;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: zero radii, every period one
    send_word(CMD_POINT, 20'sd0, 20'sd0, 20'sd0, 32'h0000_0000);
    send_word(CMD_POINT, CMIN, CMIN, CMIN, 32'hFFFF_FFFF);
    send_word(CMD_POINT, CMAX, CMAX, CMAX, 32'h0000_0000);
    send_word(CMD_POINT, CMAX, CMIN, 20'sd0, 32'hAAAA_5555);
    send_start();
    send_word(CMD_POINT, 20'sd0, 20'sd0, 20'sd0, 32'h5555_AAAA);
    drain();

    // camera on an edge, radii out of order, zero seed, zero and full periods
    program_regs(CMIN, CMAX, 20'sd0, 42'd1000, 42'd10, RAD_MAX,
                 {12'd1, 12'd3, 12'd4095, 12'd0}, 32'd0);
    send_start();
    send_point(CMIN, CMAX, 20'sd0);
    send_point(CMIN + 20'sd30, CMAX - 20'sd10, 20'sd0);
    send_point(CMIN + 20'sd30, CMAX - 20'sd10, 20'sd1);
    send_point(CMAX, CMIN, CMIN);
    send_point(CMIN + 20'sd2, CMAX, 20'sd0);
    send_point(CMIN, CMAX - 20'sd3, 20'sd0);
    send_point(CMIN + 20'sd500, CMAX - 20'sd700, 20'sd900);
    send_start();
    send_point(CMIN + 20'sd1, CMAX, 20'sd0);
    send_point(CMAX, CMAX, CMAX);

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      drain();
      program_random(phase);
      if ($urandom_range(0, 4) != 0) begin
        send_start();
      end
      if (phase % 4 == 0) begin
        hold_req <= ~hold_req;
      end
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        pick = $urandom_range(0, 99);
        k = $urandom_range(0, reach);
        if (k > 19) k = 19;
        if (pick < 3) begin
          send_start();
        end else if (pick < 6) begin
          send_point(cam_x, cam_y, cam_z);
        end else if (pick < 14) begin
          send_point(CAM_W'($urandom()), CAM_W'($urandom()), CAM_W'($urandom()));
        end else begin
          send_point(aim(cam_x, k), aim(cam_y, k), aim(cam_z, k));
        end
      end
    end
    drain();

    if (error_count == 0 && results_due == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
